/* rtl/frq_pkg.sv */
// Shared types, codes and widths for the frame ring queue.
package frq_pkg;

  localparam int CFG_W          = 5;
  localparam int FLEN_W         = 12;
  localparam int ROOM_W         = 12;
  localparam int BYTE_W         = 8;
  localparam int SLOTS_DEFAULT  = 16;
  localparam int FRAME_DEFAULT  = 2048;
  localparam int COUNT_RESET    = 16;

  // Item actions.
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_OPEN  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_NOROOM  = 3'd3,
    ST_TOOLONG = 3'd4,
    ST_NOREAD  = 3'd5
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [BYTE_W-1:0] data_byte;
    logic              frame_end;
    logic [ROOM_W-1:0] room_bytes;
  } item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [FLEN_W-1:0] frame_length;
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;
  } result_t;

endpackage

/* rtl/frq_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module frq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/frame_ring_queue.sv */
// Frame ring queue top level: control, state registers and the two slot memories.
//
// An item is taken when start is high and busy is low; busy is then high for
// one cycle while the memories return the head slot's length and byte.
// The result beat appears on result with done high in the cycle after that,
// and a new item may be started once busy is low again. The wait comes from
// the registered read of the slot memories.
// Synchronous reset empties the queue and sets the slot count to sixteen (or
// the slot limit); memory contents are left as they are and need no clearing.
module frame_ring_queue #(
  parameter int SLOTS           = frq_pkg::SLOTS_DEFAULT,
  parameter int MAX_FRAME_BYTES = frq_pkg::FRAME_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  frq_pkg::item_t            item,
  input  logic                      cfg_we,
  input  logic [frq_pkg::CFG_W-1:0] cfg_data,
  output logic                      done,
  output frq_pkg::result_t          result
);

  import frq_pkg::*;

  // Slot index, slot count, byte offset and byte address widths.
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int OFF_W   = $clog2(MAX_FRAME_BYTES + 1);
  localparam int DEPTH   = SLOTS * MAX_FRAME_BYTES;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int RST_CNT = (SLOTS < COUNT_RESET) ? SLOTS : COUNT_RESET;

  fsm_t state, state_next;
  logic exec;

  // Queue state.
  logic [CNT_W-1:0]  slot_count;
  logic [SLOT_W-1:0] read_slot, read_slot_next;
  logic [SLOT_W-1:0] write_slot, write_slot_next;
  logic [OFF_W-1:0]  write_offset, write_offset_next;
  logic [OFF_W-1:0]  read_offset, read_offset_next;
  logic              read_open, read_open_next;
  logic              write_dropping, write_dropping_next;

  item_t   item_q;
  result_t result_next;

  // Memory ports.
  logic [ADDR_W-1:0] data_raddr, data_waddr;
  logic [BYTE_W-1:0] data_rdata;
  logic              data_we;
  logic [OFF_W-1:0]  len_rdata;
  logic              len_we;

  logic [CMP_W-1:0]  cfg_wide;
  logic [CNT_W-1:0]  cfg_count;
  logic [OFF_W-1:0]  rd_off;
  logic [OFF_W-1:0]  wr_inc;
  logic [OFF_W:0]    rd_inc;
  logic              ring_full;
  logic              ring_empty;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                   input logic [CNT_W-1:0]  cnt);
    logic [SLOT_W:0] inc;
    inc = {1'b0, s} + (SLOT_W+1)'(1);
    if (CMP_W'(inc) >= CMP_W'(cnt)) begin
      return '0;
    end
    return inc[SLOT_W-1:0];
  endfunction

  // Slot count written by configuration is saturated into the legal range.
  always_comb begin
    cfg_wide = CMP_W'(cfg_data);
    if (cfg_wide < CMP_W'(2)) begin
      cfg_count = CNT_W'(2);
    end else if (cfg_wide > CMP_W'(SLOTS)) begin
      cfg_count = CNT_W'(SLOTS);
    end else begin
      cfg_count = CNT_W'(cfg_wide);
    end
  end

  // Control sequencer: the idle state takes the item and starts the memory
  // reads, the execute state uses the read data and updates the queue.
  always_comb begin
    unique case (state)
      FSM_IDLE: state_next = start ? FSM_EXEC : FSM_IDLE;
      FSM_EXEC: state_next = FSM_IDLE;
      default:  state_next = FSM_IDLE;
    endcase
  end

  always_comb begin
    unique case (state)
      FSM_IDLE: begin
        busy = 1'b0;
        exec = 1'b0;
      end
      FSM_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
        exec = 1'b0;
      end
    endcase
  end

  // The head byte address is formed from the state as it stands when the
  // item is taken; the state only moves at the end of the execute cycle or on
  // a configuration write, so a byte written in the execute cycle is visible to the next item's read.
  always_comb begin
    if (read_offset >= OFF_W'(MAX_FRAME_BYTES)) begin
      rd_off = OFF_W'(MAX_FRAME_BYTES - 1);
    end else begin
      rd_off = read_offset;
    end
    data_raddr = ADDR_W'(read_slot) * ADDR_W'(MAX_FRAME_BYTES) + ADDR_W'(rd_off);
    data_waddr = ADDR_W'(write_slot) * ADDR_W'(MAX_FRAME_BYTES) + ADDR_W'(write_offset);
  end

  assign ring_full  = (next_slot(write_slot, slot_count) == read_slot);
  assign ring_empty = (read_slot == write_slot);
  assign wr_inc     = write_offset + OFF_W'(1);
  assign rd_inc     = {1'b0, read_offset} + (OFF_W+1)'(1);

  // Execute: the result beat and the next queue state. The memories are only
  // written in the execute cycle, as the held item is stale outside it.
  always_comb begin
    read_slot_next      = read_slot;
    write_slot_next     = write_slot;
    write_offset_next   = write_offset;
    read_offset_next    = read_offset;
    read_open_next      = read_open;
    write_dropping_next = write_dropping;
    data_we             = 1'b0;
    len_we              = 1'b0;
    result_next         = '0;
    result_next.status  = ST_OK;

    unique case (item_q.action)
      ACT_WRITE: begin
        if (write_dropping) begin
          // A nonzero offset marks a frame dropped for length, zero a full ring.
          result_next.status = (write_offset != '0) ? ST_TOOLONG : ST_FULL;
          if (item_q.frame_end) begin
            write_dropping_next = 1'b0;
            write_offset_next   = '0;
          end
        end else if (write_offset == '0 && ring_full) begin
          result_next.status = ST_FULL;
          if (!item_q.frame_end) begin
            write_dropping_next = 1'b1;
          end
        end else if (write_offset >= OFF_W'(MAX_FRAME_BYTES)) begin
          result_next.status = ST_TOOLONG;
          if (item_q.frame_end) begin
            write_offset_next = '0;
          end else begin
            write_dropping_next = 1'b1;
            write_offset_next   = OFF_W'(MAX_FRAME_BYTES);
          end
        end else begin
          data_we                  = exec;
          result_next.frame_length = FLEN_W'(wr_inc);
          if (item_q.frame_end) begin
            len_we            = exec;
            write_slot_next   = next_slot(write_slot, slot_count);
            write_offset_next = '0;
          end else begin
            write_offset_next = wr_inc;
          end
        end
      end
      ACT_OPEN: begin
        read_offset_next = '0;
        if (ring_empty) begin
          result_next.status = ST_EMPTY;
          read_open_next     = 1'b0;
        end else begin
          result_next.frame_length = FLEN_W'(len_rdata);
          if (len_rdata > item_q.room_bytes) begin
            result_next.status = ST_NOROOM;
            read_open_next     = 1'b0;
          end else begin
            read_open_next = 1'b1;
          end
        end
      end
      ACT_READ: begin
        if (!read_open || ring_empty) begin
          result_next.status = ST_NOREAD;
          read_open_next     = 1'b0;
        end else begin
          result_next.out_byte     = data_rdata;
          result_next.frame_length = FLEN_W'(rd_inc);
          read_offset_next         = rd_inc[OFF_W-1:0];
          if (rd_inc >= {1'b0, len_rdata}) begin
            result_next.out_last = 1'b1;
            read_slot_next       = next_slot(read_slot, slot_count);
            read_open_next       = 1'b0;
            read_offset_next     = '0;
          end
        end
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= FSM_IDLE;
      done           <= 1'b0;
      slot_count     <= CNT_W'(RST_CNT);
      read_slot      <= '0;
      write_slot     <= '0;
      write_offset   <= '0;
      read_offset    <= '0;
      read_open      <= 1'b0;
      write_dropping <= 1'b0;
    end else begin
      state <= state_next;
      done  <= exec;
      if (cfg_we) begin
        // A new slot count empties the queue.
        slot_count     <= cfg_count;
        read_slot      <= '0;
        write_slot     <= '0;
        write_offset   <= '0;
        read_offset    <= '0;
        read_open      <= 1'b0;
        write_dropping <= 1'b0;
      end else if (exec) begin
        read_slot      <= read_slot_next;
        write_slot     <= write_slot_next;
        write_offset   <= write_offset_next;
        read_offset    <= read_offset_next;
        read_open      <= read_open_next;
        write_dropping <= write_dropping_next;
      end
    end
  end

  // Payload registers: the taken item and the result beat.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_q <= item;
    end
    if (exec) begin
      result <= result_next;
    end
  end

  // Frame bytes, one slot of MAX_FRAME_BYTES per frame.
  frq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (item_q.data_byte),
    .raddr (data_raddr),
    .rdata (data_rdata)
  );

  // Committed frame length of each slot.
  frq_ram #(
    .WIDTH (OFF_W),
    .DEPTH (SLOTS)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (write_slot),
    .wdata (wr_inc),
    .raddr (read_slot),
    .rdata (len_rdata)
  );

  // A result beat only follows an execute cycle.
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without an execute cycle");

  // Both ring indices stay inside the configured slot count.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (CMP_W'(read_slot) < CMP_W'(slot_count)) && (CMP_W'(write_slot) < CMP_W'(slot_count)))
    else $error("ring index beyond slot count");

  // The write offset never passes the slot size.
  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    write_offset <= OFF_W'(MAX_FRAME_BYTES))
    else $error("write offset beyond slot size");

  // An open read always refers to a queued frame.
  a_open_nonempty: assert property (@(posedge clk) disable iff (rst)
    read_open |-> !ring_empty)
    else $error("read open on an empty ring");

  // A taken item is executed in the following cycle.
  a_take_exec: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> exec)
    else $error("taken item not executed");

endmodule
